FILE: sv/bmi_pkg.sv
package bmi_pkg;

    // Fixed field widths of the channels and the configuration port
    localparam int DATA_W     = 8;
    localparam int COUNT_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Default geometry limits and element width
    localparam int DEF_MAX_ROWS      = 8;
    localparam int DEF_MAX_COLS      = 8;
    localparam int DEF_ELEMENT_WIDTH = 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_VALUE = 2'd3;

    // Register reset values
    localparam logic [COUNT_W-1:0]    ROW_COUNT_RST = 4'd8;
    localparam logic [COUNT_W-1:0]    COL_COUNT_RST = 4'd8;
    localparam logic                  DIRECTION_RST = 1'b0;
    localparam logic [CFG_DATA_W-1:0] PAD_VALUE_RST = 8'd0;

    // Controller to datapath
    typedef struct packed {
        logic wr_data;     // store the accepted element, advance write position
        logic wr_pad;      // store pad value, advance write position
        logic clr_pos;     // drop partial block
        logic latch_last;  // capture in_last of the accepted beat
        logic issue;       // read next output cell into the output register
    } bmi_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_at_end;   // write position is the final cell of the block
        logic out_at_end;  // read position is the final cell of the block
        logic dir;         // 1 deinterleave
        logic out_free;    // output register can take a new beat this cycle
    } bmi_status_t;

endpackage

FILE: sv/bmi_in_if.sv
interface bmi_in_if;
    logic                        valid;
    logic                        ready;
    logic [bmi_pkg::DATA_W-1:0]  in_data;
    logic                        in_last;

    modport source (output valid, output in_data, output in_last, input ready);
    modport sink   (input valid, input in_data, input in_last, output ready);
endinterface

FILE: sv/bmi_out_if.sv
interface bmi_out_if;
    logic                        valid;
    logic                        ready;
    logic [bmi_pkg::DATA_W-1:0]  out_data;
    logic                        block_end;
    logic                        message_end;

    modport source (output valid, output out_data, output block_end, output message_end,
                    input ready);
    modport sink   (input valid, input out_data, input block_end, input message_end,
                    output ready);
endinterface

FILE: sv/bmi_ctrl.sv
module bmi_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_last,
    output logic                 in_ready,
    input  bmi_pkg::bmi_status_t status,
    output bmi_pkg::bmi_cmd_t    cmd
);
    import bmi_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PAD  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       in_fire;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.wr_data    = 1'b1;
                    cmd.latch_last = 1'b1;
                    if (status.in_at_end)
                    begin
                        state_next = ST_EMIT;
                    end
                    else if (in_last)
                    begin
                        if (status.dir)
                        begin
                            cmd.clr_pos = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_PAD;
                        end
                    end
                end
            end
            ST_PAD:
            begin
                cmd.wr_pad = 1'b1;
                if (status.in_at_end)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.issue = status.out_free;
                if (status.out_free && status.out_at_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: sv/bmi_datapath.sv
module bmi_datapath #(
    parameter int MAX_ROWS      = bmi_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS      = bmi_pkg::DEF_MAX_COLS,
    parameter int ELEMENT_WIDTH = bmi_pkg::DEF_ELEMENT_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bmi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bmi_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [bmi_pkg::DATA_W-1:0]      in_data,
    input  logic                            in_last,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [bmi_pkg::DATA_W-1:0]      out_data,
    output logic                            block_end,
    output logic                            message_end,
    input  bmi_pkg::bmi_cmd_t               cmd,
    output bmi_pkg::bmi_status_t            status
);
    import bmi_pkg::*;

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DEPTH = 1 << (RW + CW);

    // Configuration
    logic [COUNT_W-1:0]    row_count_reg;
    logic [COUNT_W-1:0]    col_count_reg;
    logic                  direction_reg;
    logic [CFG_DATA_W-1:0] pad_value_reg;

    // Write and read positions
    logic [RW-1:0] in_row_reg,  in_row_next;
    logic [CW-1:0] in_col_reg,  in_col_next;
    logic [RW-1:0] out_row_reg, out_row_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic          last_reg;

    // Output register
    logic                     out_valid_reg;
    logic [ELEMENT_WIDTH-1:0] rd_reg;
    logic                     bend_reg;
    logic                     mend_reg;

    logic [ELEMENT_WIDTH-1:0] cell_mem [DEPTH];

    logic [RW-1:0]            r_last;
    logic [CW-1:0]            c_last;
    logic                     geom_wr;
    logic                     wr_en;
    logic [ELEMENT_WIDTH-1:0] wr_val;
    logic                     in_end, out_end;

    // Clamp geometry to 1..MAX, kept as last index
    always_comb
    begin
        if (row_count_reg == '0)
            r_last = '0;
        else if (row_count_reg > COUNT_W'(MAX_ROWS))
            r_last = RW'(MAX_ROWS - 1);
        else
            r_last = RW'(row_count_reg - COUNT_W'(1));

        if (col_count_reg == '0)
            c_last = '0;
        else if (col_count_reg > COUNT_W'(MAX_COLS))
            c_last = CW'(MAX_COLS - 1);
        else
            c_last = CW'(col_count_reg - COUNT_W'(1));
    end

    assign in_end  = (in_row_reg == r_last) && (in_col_reg == c_last);
    assign out_end = (out_row_reg == r_last) && (out_col_reg == c_last);

    // Write walk: row-major when interleaving, column-major when deinterleaving
    always_comb
    begin
        in_row_next = in_row_reg;
        in_col_next = in_col_reg;
        if (direction_reg)
        begin
            if (in_row_reg == r_last)
            begin
                in_row_next = '0;
                in_col_next = (in_col_reg == c_last) ? '0 : in_col_reg + CW'(1);
            end
            else
                in_row_next = in_row_reg + RW'(1);
        end
        else
        begin
            if (in_col_reg == c_last)
            begin
                in_col_next = '0;
                in_row_next = (in_row_reg == r_last) ? '0 : in_row_reg + RW'(1);
            end
            else
                in_col_next = in_col_reg + CW'(1);
        end
    end

    // Read walk: the opposite order
    always_comb
    begin
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        if (!direction_reg)
        begin
            if (out_row_reg == r_last)
            begin
                out_row_next = '0;
                out_col_next = (out_col_reg == c_last) ? '0 : out_col_reg + CW'(1);
            end
            else
                out_row_next = out_row_reg + RW'(1);
        end
        else
        begin
            if (out_col_reg == c_last)
            begin
                out_col_next = '0;
                out_row_next = (out_row_reg == r_last) ? '0 : out_row_reg + RW'(1);
            end
            else
                out_col_next = out_col_reg + CW'(1);
        end
    end

    assign geom_wr = cfg_we && ((cfg_index == REG_ROW_COUNT) ||
                                (cfg_index == REG_COL_COUNT) ||
                                (cfg_index == REG_DIRECTION));
    assign wr_en   = cmd.wr_data || cmd.wr_pad;
    assign wr_val  = cmd.wr_pad ? pad_value_reg[ELEMENT_WIDTH-1:0]
                                : in_data[ELEMENT_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= ROW_COUNT_RST;
            col_count_reg <= COL_COUNT_RST;
            direction_reg <= DIRECTION_RST;
            pad_value_reg <= PAD_VALUE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROW_COUNT: row_count_reg <= cfg_data[COUNT_W-1:0];
                REG_COL_COUNT: col_count_reg <= cfg_data[COUNT_W-1:0];
                REG_DIRECTION: direction_reg <= cfg_data[0];
                REG_PAD_VALUE: pad_value_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (geom_wr || cmd.clr_pos)
            begin
                in_row_reg <= '0;
                in_col_reg <= '0;
            end
            else if (wr_en)
            begin
                in_row_reg <= in_row_next;
                in_col_reg <= in_col_next;
            end

            if (cmd.latch_last)
                last_reg <= in_last;

            if (cmd.issue)
            begin
                out_row_reg   <= out_row_next;
                out_col_reg   <= out_col_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Block store and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            cell_mem[{in_row_reg, in_col_reg}] <= wr_val;
        if (cmd.issue)
        begin
            rd_reg   <= cell_mem[{out_row_reg, out_col_reg}];
            bend_reg <= out_end;
            mend_reg <= out_end && last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_data    = DATA_W'(rd_reg);
    assign block_end   = bend_reg;
    assign message_end = mend_reg;

    always_comb
    begin
        status.in_at_end  = in_end;
        status.out_at_end = out_end;
        status.dir        = direction_reg;
        status.out_free   = !out_valid_reg || out_ready;
    end

endmodule

FILE: sv/block_matrix_interleaver_unit.sv
// Row-column block interleaver. Elements enter one per beat and fill a block of
// row_count x col_count cells: row by row when interleaving (direction 0), column
// by column when deinterleaving (direction 1). The element that completes a block
// starts emission: the block's R*C elements leave in the opposite order at one beat
// per cycle while the sink is ready, block_end marks the final beat of a block and
// message_end the final beat of a block closed by in_last. No element is taken
// while a block is padded or emitted: the single block buffer is either being
// filled or being emitted. When in_last arrives on a partial block, interleave
// mode writes pad_value into the remaining cells and then emits the block;
// deinterleave mode drops the partial block without output. Counts of 0 act as 1
// and counts above the maximum act as the maximum. Writing row_count, col_count or
// direction discards a partial block; the user must see that registers are written
// only while the block is idle, which the block itself does not enforce.
module block_matrix_interleaver_unit #(
    parameter int MAX_ROWS      = bmi_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS      = bmi_pkg::DEF_MAX_COLS,
    parameter int ELEMENT_WIDTH = bmi_pkg::DEF_ELEMENT_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bmi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bmi_pkg::CFG_DATA_W-1:0] cfg_data,
    bmi_in_if.sink                         in_ch,
    bmi_out_if.source                      out_ch
);
    import bmi_pkg::*;

    bmi_cmd_t    cmd;      // controller commands to the datapath
    bmi_status_t status;   // datapath position and output status

    // Sequencer: accept, pad, emit
    bmi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_last  (in_ch.in_last),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Registers, block store, position walkers and output register
    bmi_datapath #(
        .MAX_ROWS      (MAX_ROWS),
        .MAX_COLS      (MAX_COLS),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_data     (in_ch.in_data),
        .in_last     (in_ch.in_last),
        .out_ready   (out_ch.ready),
        .out_valid   (out_ch.valid),
        .out_data    (out_ch.out_data),
        .block_end   (out_ch.block_end),
        .message_end (out_ch.message_end),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

FILE: sim/interleave_checker.sv
`timescale 1ns / 100ps

module interleave_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bmi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bmi_pkg::CFG_DATA_W-1:0] cfg_data,
    bmi_in_if                              in_ch,
    bmi_out_if                             out_ch,
    output int                             mismatch_count,
    output int                             due_count
);
    import bmi_pkg::*;

    localparam int MAX_DIM_R = DEF_MAX_ROWS;
    localparam int MAX_DIM_C = DEF_MAX_COLS;
    localparam int CELLS     = DEF_MAX_ROWS * DEF_MAX_COLS;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              block_end;
        logic              message_end;
    } elem_beat_t;

    // shadow registers and block store
    logic [COUNT_W-1:0] rows_reg;
    logic [COUNT_W-1:0] cols_reg;
    logic               dir_reg;
    logic [DATA_W-1:0]  pad_reg;
    logic [DATA_W-1:0]  cells [CELLS];
    int                 fill_pos;
    int                 err_total;
    elem_beat_t         due_q [$];

    function automatic int clamp_dim(input logic [COUNT_W-1:0] v, input int max_dim);
        if (v == '0)
            return 1;
        if (int'(v) > max_dim)
            return max_dim;
        return int'(v);
    endfunction

    // cell hit by write position pos
    function automatic int cell_in(input int pos, input int r, input int c);
        if (dir_reg)
            return ((pos % r) * c + pos / r) % CELLS;
        return pos % CELLS;
    endfunction

    // cell read at output position k
    function automatic int cell_out(input int k, input int r, input int c);
        if (dir_reg)
            return k % CELLS;
        return ((k % r) * c + k / r) % CELLS;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        err_total++;
    endtask

    task automatic absorb_element(input logic [DATA_W-1:0] d, input logic tail);
        int         r;
        int         c;
        int         n;
        logic       emit;
        elem_beat_t b;
        r = clamp_dim(rows_reg, MAX_DIM_R);
        c = clamp_dim(cols_reg, MAX_DIM_C);
        n = r * c;
        emit = 1'b1;
        if (fill_pos >= n)
            fill_pos = 0;
        cells[cell_in(fill_pos, r, c)] = d;
        fill_pos++;
        if (fill_pos < n)
        begin
            if (!tail)
                emit = 1'b0;
            else if (dir_reg)
            begin
                // deinterleave drops a trailing partial block
                fill_pos = 0;
                emit = 1'b0;
            end
            else
            begin
                while (fill_pos < n)
                begin
                    cells[cell_in(fill_pos, r, c)] = pad_reg;
                    fill_pos++;
                end
            end
        end
        if (emit)
        begin
            for (int k = 0; k < n; k++)
            begin
                b.data        = cells[cell_out(k, r, c)];
                b.block_end   = (k == n - 1);
                b.message_end = (k == n - 1) && tail;
                due_q.insert(due_q.size(), b);
            end
            fill_pos = 0;
        end
    endtask

    task automatic check_beat();
        elem_beat_t b;
        if (due_q.size() == 0)
        begin
            flag_mismatch($sformatf("unexpected beat data=%02h", out_ch.out_data));
        end
        else
        begin
            b = due_q.pop_front();
            if (out_ch.out_data !== b.data)
                flag_mismatch($sformatf("out_data %02h, want %02h", out_ch.out_data, b.data));
            if (out_ch.block_end !== b.block_end)
                flag_mismatch($sformatf("block_end %b, want %b", out_ch.block_end,
                                        b.block_end));
            if (out_ch.message_end !== b.message_end)
                flag_mismatch($sformatf("message_end %b, want %b", out_ch.message_end,
                                        b.message_end));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  = ROW_COUNT_RST;
            cols_reg  = COL_COUNT_RST;
            dir_reg   = DIRECTION_RST;
            pad_reg   = PAD_VALUE_RST;
            fill_pos  = 0;
            err_total = 0;
            due_q.delete();
            mismatch_count <= 0;
            due_count      <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ROW_COUNT:
                    begin
                        rows_reg = cfg_data[COUNT_W-1:0];
                        fill_pos = 0;
                    end
                    REG_COL_COUNT:
                    begin
                        cols_reg = cfg_data[COUNT_W-1:0];
                        fill_pos = 0;
                    end
                    REG_DIRECTION:
                    begin
                        dir_reg  = cfg_data[0];
                        fill_pos = 0;
                    end
                    REG_PAD_VALUE:
                        pad_reg = cfg_data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                absorb_element(in_ch.in_data, in_ch.in_last);
            if (out_ch.valid && out_ch.ready)
                check_beat();
            mismatch_count <= err_total;
            due_count      <= due_q.size();
        end
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

// Stimulus and verdict. The checker beside the DUT watches both channels and
// the register port; this module only drives them and decides pass/fail.
module testbench;
    import bmi_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no beat and no write
    localparam int SETTLE_CYCLES  = 20;    // covers pad walk tail / drop cleanup
    localparam int RANDOM_ITEMS   = 360;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  steady_flow;   // no gaps, no stalls for this phase
    int                    mismatch_count;
    int                    due_count;
    int                    idle_cycles;
    int                    ready_left;
    logic [COUNT_W-1:0]    cur_rows;
    logic [COUNT_W-1:0]    cur_cols;

    bmi_in_if  in_ch ();
    bmi_out_if out_ch ();

    block_matrix_interleaver_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    interleave_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_ch          (in_ch),
        .out_ch         (out_ch),
        .mismatch_count (mismatch_count),
        .due_count      (due_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sink side: ready held for random runs; low runs are mostly short with the
    // odd long stall. During steady phases ready stays high.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (steady_flow)
            out_ch.ready <= 1'b1;
        else if (ready_left > 0)
            ready_left--;
        else if ($urandom_range(0, 99) < 65)
        begin
            out_ch.ready <= 1'b1;
            ready_left = $urandom_range(0, 7);
        end
        else
        begin
            out_ch.ready <= 1'b0;
            ready_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                      : $urandom_range(8, 30);
        end
    end

    // Watchdog: any beat or register write counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) ||
            (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Source-side gap before a beat: mostly none, some short, a few long.
    function automatic int draw_gap();
        int p;
        p = $urandom_range(0, 99);
        if (steady_flow || p < 60)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int eff_dim(input logic [COUNT_W-1:0] v, input int max_dim);
        if (v == '0)
            return 1;
        if (int'(v) > max_dim)
            return max_dim;
        return int'(v);
    endfunction

    // One input beat. valid stays high into the next beat when there is no gap,
    // so it never gets a second assignment in the same step.
    task automatic push_elem(input logic [DATA_W-1:0] d, input logic tail);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_data <= d;
        in_ch.in_last <= tail;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // Drop valid, wait for every predicted beat to come out, then let the
    // block settle (a dropped deinterleave block leaves no beat to wait on).
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (due_count != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
    endtask

    // Writes the registers selected by sel (bit per register index). Unused
    // upper bits of cfg_data carry random junk, the block must ignore them.
    task automatic program_regs(input logic [COUNT_W-1:0] rows, input logic [COUNT_W-1:0] cols,
                                input logic dir, input logic [DATA_W-1:0] pad,
                                input logic [3:0] sel);
        if (sel[REG_ROW_COUNT])
        begin
            put_reg(REG_ROW_COUNT, {4'($urandom), rows});
            cur_rows = rows;
        end
        if (sel[REG_COL_COUNT])
        begin
            put_reg(REG_COL_COUNT, {4'($urandom), cols});
            cur_cols = cols;
        end
        if (sel[REG_DIRECTION])
            put_reg(REG_DIRECTION, {7'($urandom), dir});
        if (sel[REG_PAD_VALUE])
            put_reg(REG_PAD_VALUE, pad);
        cfg_we <= 1'b0;
    endtask

    // Random message: random content, in_last at the tail when closed, and
    // in noisy mode stray in_last bits that cut it into short messages.
    task automatic send_message(input int len, input logic closed, input logic noisy);
        logic tail;
        for (int i = 0; i < len; i++)
        begin
            if (i == len - 1)
                tail = closed;
            else
                tail = noisy && ($urandom_range(0, 3) == 0);
            push_elem(8'($urandom), tail);
        end
    endtask

    // Geometry draw: mostly small blocks, some up to the maximum, and some
    // out of range (zero acts as one, above the maximum acts as the maximum).
    function automatic logic [COUNT_W-1:0] draw_dim();
        int p;
        p = $urandom_range(0, 99);
        if (p < 65)
            return COUNT_W'($urandom_range(1, 4));
        if (p < 85)
            return COUNT_W'($urandom_range(5, 8));
        if (p < 92)
            return '0;
        return COUNT_W'($urandom_range(9, 15));
    endfunction

    initial
    begin
        int                 sent;
        int                 phase;
        int                 n_msgs;
        int                 blk;
        int                 len;
        logic [3:0]         sel;
        logic [COUNT_W-1:0] rows;
        logic [COUNT_W-1:0] cols;
        logic               dir;

        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_ROW_COUNT;
        cfg_data      = '0;
        steady_flow   = 1'b0;
        idle_cycles   = 0;
        ready_left    = 0;
        cur_rows      = ROW_COUNT_RST;
        cur_cols      = COL_COUNT_RST;
        in_ch.valid   = 1'b0;
        in_ch.in_data = '0;
        in_ch.in_last = 1'b0;
        out_ch.ready  = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 2x3 interleave: full block with no in_last (block_end only), then a
        // closed partial block that gets two pad cells.
        program_regs(4'd2, 4'd3, 1'b0, 8'hA5, 4'b1111);
        push_elem(8'h00, 1'b0);
        push_elem(8'hFF, 1'b0);
        push_elem(8'h01, 1'b0);
        push_elem(8'h80, 1'b0);
        push_elem(8'h7F, 1'b0);
        push_elem(8'hFE, 1'b0);
        push_elem(8'h55, 1'b0);
        push_elem(8'hAA, 1'b0);
        push_elem(8'h0F, 1'b0);
        push_elem(8'hF0, 1'b1);
        wait_drained();

        // 3x2 deinterleave: full block closed by in_last, then a partial
        // block closed by in_last that must vanish without output.
        program_regs(4'd3, 4'd2, 1'b1, 8'h00, 4'b0111);
        push_elem(8'h12, 1'b0);
        push_elem(8'h34, 1'b0);
        push_elem(8'h56, 1'b0);
        push_elem(8'h78, 1'b0);
        push_elem(8'h9A, 1'b0);
        push_elem(8'hBC, 1'b1);
        push_elem(8'hDE, 1'b0);
        push_elem(8'hF1, 1'b1);
        wait_drained();

        // zero counts act as 1x1: every element is its own block
        program_regs(4'd0, 4'd0, 1'b0, 8'hFF, 4'b1111);
        push_elem(8'hC3, 1'b0);
        push_elem(8'h3C, 1'b1);
        wait_drained();

        // 2x2: a partial block survives a pad_value write and is completed
        program_regs(4'd2, 4'd2, 1'b0, 8'h00, 4'b0011);
        push_elem(8'h11, 1'b0);
        push_elem(8'h22, 1'b0);
        push_elem(8'h33, 1'b0);
        wait_drained();
        program_regs(4'd2, 4'd2, 1'b0, 8'h5A, 4'b1000);
        push_elem(8'h44, 1'b1);
        wait_drained();

        // Random phases. A phase may rewrite any subset of the registers; with
        // no geometry write a leftover partial block carries over, with one it
        // is discarded. Most messages are closed by in_last.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_drained();
            steady_flow <= ($urandom_range(0, 4) == 0);
            if (phase == 0)
            begin
                rows = 4'd8;
                cols = 4'd8;
                dir  = 1'b0;
                sel  = 4'b1111;
            end
            else if (phase == 1)
            begin
                rows = 4'd15;
                cols = 4'd12;
                dir  = 1'b1;
                sel  = 4'b1111;
            end
            else
            begin
                rows = draw_dim();
                cols = draw_dim();
                dir  = 1'($urandom);
                sel  = ($urandom_range(0, 99) < 80) ? 4'($urandom) : 4'b0000;
            end
            program_regs(rows, cols, dir, 8'($urandom), sel);
            blk    = eff_dim(cur_rows, DEF_MAX_ROWS) * eff_dim(cur_cols, DEF_MAX_COLS);
            n_msgs = $urandom_range(1, 3);
            for (int m = 0; m < n_msgs; m++)
            begin
                len = $urandom_range(1, 2 * blk + 1);
                send_message(len, $urandom_range(0, 99) < 85, $urandom_range(0, 9) == 0);
                sent += len;
            end
            phase++;
        end

        wait_drained();
        if (mismatch_count == 0 && due_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
